>>> hw/rtl/mfep_pkg.sv
// Package for the 3x3 edge-padded median filter: pixel and window types,
// configuration register codes, reset values and the nine-input median network.
// No dependencies.
`default_nettype none

package mfep_pkg;

  localparam int PIX_W         = 8;
  localparam int ROW_W         = 16;
  localparam int COL_W         = 12;
  localparam int IMG_W_W       = 13;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MIN_DIM       = 2;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 13'd640;
  localparam logic [ROW_W-1:0]   IMG_H_RST = 16'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // block of rows r-2..r (first index) and columns c-2..c (second index)
  typedef pix_t [2:0][2:0] blk_t;

  // padded 3x3 window, row-major
  typedef pix_t [8:0] win_t;

  // line buffer entry: rows r-2 and r-1 of one column
  typedef struct packed {
    pix_t older;
    pix_t recent;
  } line_pair_t;

  // which sides of the window fall on the image padding
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } pad_t;

  typedef struct packed {
    pix_t lo;
    pix_t hi;
  } pix_pair_t;

  function automatic pix_pair_t sort2(input pix_t a, input pix_t b);
    pix_pair_t p;
    if (a > b) begin
      p.lo = b;
      p.hi = a;
    end else begin
      p.lo = a;
      p.hi = b;
    end
    return p;
  endfunction

  // 19 compare-exchange median network, result lands in element four
  function automatic pix_t median9(input win_t w);
    pix_t v [9];
    for (int k = 0; k < 9; k++) begin
      v[k] = w[k];
    end
    {v[1], v[2]} = sort2(v[1], v[2]);
    {v[4], v[5]} = sort2(v[4], v[5]);
    {v[7], v[8]} = sort2(v[7], v[8]);
    {v[0], v[1]} = sort2(v[0], v[1]);
    {v[3], v[4]} = sort2(v[3], v[4]);
    {v[6], v[7]} = sort2(v[6], v[7]);
    {v[1], v[2]} = sort2(v[1], v[2]);
    {v[4], v[5]} = sort2(v[4], v[5]);
    {v[7], v[8]} = sort2(v[7], v[8]);
    {v[0], v[3]} = sort2(v[0], v[3]);
    {v[5], v[8]} = sort2(v[5], v[8]);
    {v[4], v[7]} = sort2(v[4], v[7]);
    {v[3], v[6]} = sort2(v[3], v[6]);
    {v[1], v[4]} = sort2(v[1], v[4]);
    {v[2], v[5]} = sort2(v[2], v[5]);
    {v[4], v[7]} = sort2(v[4], v[7]);
    {v[4], v[2]} = sort2(v[4], v[2]);
    {v[6], v[4]} = sort2(v[6], v[4]);
    {v[4], v[2]} = sort2(v[4], v[2]);
    return v[4];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/median_filter_3x3_edge_pad.sv
// Top level of the 3x3 median filter with one-pixel edge padding.
// Uses mfep_pkg, mfep_line_buf and mfep_kernel.
//
//  channel  ports                                            beat
//  -------  -----------------------------------------------  -------------------------
//  in       in_valid, in_ready, in_pixel                     one pixel, raster order
//  out      out_valid, out_ready, out_median, out_row,       one filtered pixel
//           out_col, out_last_of_run
//  cfg      cfg_we, cfg_idx, cfg_wdata                       register write, no wait
//
// A pixel sits in the window stage from its accepting edge; its results go into the
// output register as that register is free. A new pixel is taken as the last one
// finishes, which for a pixel that also flushes right-edge and last-row outputs is
// once all its results (up to four, one median unit and output register) are loaded.
// Pixels on row 0 or column 0 give no result. Reset clears control state, holds
// in_ready low and sets 640 x 480; the line buffer needs no clearing.
// A stalled output holds the window stage, which then drops in_ready.
`default_nettype none

module median_filter_3x3_edge_pad #(
  parameter int MAX_WIDTH = mfep_pkg::MAX_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire [mfep_pkg::PIX_W-1:0]           in_pixel,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mfep_pkg::PIX_W-1:0]          out_median,
  output logic [mfep_pkg::ROW_W-1:0]          out_row,
  output logic [mfep_pkg::COL_W-1:0]          out_col,
  output logic                                out_last_of_run,
  input  wire                                 cfg_we,
  input  wire [mfep_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire [mfep_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mfep_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {
    SEL_MAIN,
    SEL_RIGHT,
    SEL_BOTTOM,
    SEL_CORNER
  } res_sel_t;

  // configuration and position
  logic [IMG_W_W-1:0] cfg_width_r;
  logic [ROW_W-1:0]   cfg_height_r;
  logic [CW-1:0]      col_r;
  logic [ROW_W-1:0]   row_r;
  logic [CW-1:0]      col_nxt;
  logic [ROW_W-1:0]   row_nxt;
  logic [WW-1:0]      eff_w;
  logic [ROW_W-1:0]   eff_h;
  logic [CW-1:0]      c_eff;
  logic [ROW_W-1:0]   r_eff;
  logic [WW-1:0]      c_inc;

  // window stage
  logic               s1_valid_r;
  res_sel_t           s1_sel_r;
  logic               s1_emit_r;
  logic               s1_right_r;
  logic               s1_bot_r;
  logic               s1_row1_r;
  logic               s1_col1_r;
  pix_t               s1_pix_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [CW-1:0]      s1_col_r;
  pix_t               win_cols_r [6];
  line_pair_t         line_rd;
  line_pair_t         line_wr;
  blk_t               blk;
  pad_t               pad;
  pix_t               med;

  // sequencing of results
  res_sel_t           sel_nxt;
  logic               more;
  logic               emit_ok;
  logic               s1_fire;
  logic               s1_done;
  logic               in_fire;
  logic [ROW_W-1:0]   res_row;
  logic [CW-1:0]      res_col;

  // output register
  logic               out_valid_r;
  pix_t               out_median_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic               out_last_r;

  // ---------------------------------------------------------------- position
  always_comb begin
    if (cfg_width_r < IMG_W_W'(MIN_DIM)) begin
      eff_w = WW'(MIN_DIM);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_width_r);
    end
    eff_h = (cfg_height_r < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg_height_r;
    c_eff = (WW'(col_r) >= eff_w) ? '0 : col_r;
    r_eff = (row_r >= eff_h) ? '0 : row_r;
    c_inc = WW'(c_eff) + WW'(1);
    if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = ((r_eff + ROW_W'(1)) >= eff_h) ? '0 : (r_eff + ROW_W'(1));
    end else begin
      col_nxt = CW'(c_inc);
      row_nxt = r_eff;
    end
  end

  // ---------------------------------------------------------------- handshakes
  always_comb begin
    sel_nxt = s1_sel_r;
    more    = 1'b0;
    unique case (s1_sel_r)
      SEL_MAIN: begin
        if (s1_right_r) begin
          sel_nxt = SEL_RIGHT;
          more    = 1'b1;
        end else if (s1_bot_r) begin
          sel_nxt = SEL_BOTTOM;
          more    = 1'b1;
        end
      end
      SEL_RIGHT: begin
        if (s1_bot_r) begin
          sel_nxt = SEL_BOTTOM;
          more    = 1'b1;
        end
      end
      SEL_BOTTOM: begin
        if (s1_right_r) begin
          sel_nxt = SEL_CORNER;
          more    = 1'b1;
        end
      end
      SEL_CORNER: begin
        more = 1'b0;
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  assign emit_ok  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_emit_r && emit_ok;
  assign s1_done  = s1_valid_r && (!s1_emit_r || (emit_ok && !more));
  assign in_ready = rst_n && (!s1_valid_r || s1_done);
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------- line buffer
  assign line_wr.older  = line_rd.recent;
  assign line_wr.recent = s1_pix_r;

  mfep_line_buf #(
    .DEPTH   (MAX_WIDTH),
    .AW      (CW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_done),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_en   (in_fire),
    .rd_addr (c_eff),
    .rd_data (line_rd)
  );

  // ---------------------------------------------------------------- window and median
  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      blk[dy][0] = win_cols_r[dy];
      blk[dy][1] = win_cols_r[3 + dy];
    end
    blk[0][2] = line_rd.older;
    blk[1][2] = line_rd.recent;
    blk[2][2] = s1_pix_r;

    pad.top    = s1_row1_r && ((s1_sel_r == SEL_MAIN) || (s1_sel_r == SEL_RIGHT));
    pad.bottom = (s1_sel_r == SEL_BOTTOM) || (s1_sel_r == SEL_CORNER);
    pad.left   = s1_col1_r && ((s1_sel_r == SEL_MAIN) || (s1_sel_r == SEL_BOTTOM));
    pad.right  = (s1_sel_r == SEL_RIGHT) || (s1_sel_r == SEL_CORNER);

    // last-row outputs sit on the current row, right-edge ones on the current column
    res_row = pad.bottom ? s1_row_r : (s1_row_r - ROW_W'(1));
    res_col = pad.right ? s1_col_r : (s1_col_r - CW'(1));
  end

  mfep_kernel u_kernel (
    .blk    (blk),
    .pad    (pad),
    .median (med)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= IMG_W_RST;
      cfg_height_r <= IMG_H_RST;
      col_r        <= '0;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
      s1_sel_r     <= SEL_MAIN;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        win_cols_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_IMAGE_WIDTH: begin
            cfg_width_r <= cfg_wdata[IMG_W_W-1:0];
          end
          REG_IMAGE_HEIGHT: begin
            cfg_height_r <= cfg_wdata[ROW_W-1:0];
          end
          default: begin
            cfg_width_r <= cfg_width_r;
          end
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_sel_r   <= SEL_MAIN;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end else if (s1_fire) begin
        s1_sel_r <= sel_nxt;
      end

      // shift the two-column window once the pixel is finished with
      if (s1_done) begin
        for (int k = 0; k < 3; k++) begin
          win_cols_r[k] <= win_cols_r[3 + k];
        end
        win_cols_r[3] <= line_rd.older;
        win_cols_r[4] <= line_rd.recent;
        win_cols_r[5] <= s1_pix_r;
      end

      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_pixel;
      s1_row_r   <= r_eff;
      s1_col_r   <= c_eff;
      s1_emit_r  <= (r_eff != '0) && (c_eff != '0);
      s1_right_r <= (WW'(c_eff) == (eff_w - WW'(1)));
      s1_bot_r   <= (r_eff == (eff_h - ROW_W'(1)));
      s1_row1_r  <= (r_eff == ROW_W'(1));
      s1_col1_r  <= (c_eff == CW'(1));
    end
    if (s1_fire) begin
      out_median_r <= med;
      out_row_r    <= res_row;
      out_col_r    <= COL_W'(res_col);
      out_last_r   <= !more;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_median      = out_median_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_of_run = out_last_r;

  // ---------------------------------------------------------------- assertions
  a_pending_keeps_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && more |=> s1_valid_r)
    else $error("pixel left the window stage with results still owed");

  a_blocked_no_accept : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while the window stage is blocked");

  a_corner_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_sel_r == SEL_CORNER) |-> !more)
    else $error("result sequence continues past the corner output");

  a_last_flag : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && (out_last_of_run == $past(s1_done)))
    else $error("last-of-run flag disagrees with pixel completion");

endmodule

`default_nettype wire

>>> hw/rtl/mfep_line_buf.sv
// Two-row line buffer of the median filter, one entry per image column.
// One write port, one read port with registered read data. Uses mfep_pkg.
`default_nettype none

module mfep_line_buf #(
  parameter int DEPTH = mfep_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire [AW-1:0]              wr_addr,
  input  mfep_pkg::line_pair_t      wr_data,
  input  wire                       rd_en,
  input  wire [AW-1:0]              rd_addr,
  output mfep_pkg::line_pair_t      rd_data
);
  import mfep_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read so a stalled pixel keeps its column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/mfep_kernel.sv
// Padded window builder and median network of the median filter.
// Maps the 3x3 block onto the padded neighbourhood and sorts. Uses mfep_pkg.
`default_nettype none

module mfep_kernel (
  input  mfep_pkg::blk_t  blk,
  input  mfep_pkg::pad_t  pad,
  output mfep_pkg::pix_t  median
);
  import mfep_pkg::*;

  logic [2:0][1:0] rsel;
  logic [2:0][1:0] csel;
  logic [2:0]      rpad;
  logic [2:0]      cpad;
  win_t            win;

  always_comb begin
    // a pad row repeats its neighbour, the last-row window is rows r-1, r, r
    rsel[0] = (pad.top || pad.bottom) ? 2'd1 : 2'd0;
    rsel[1] = pad.bottom ? 2'd2 : 2'd1;
    rsel[2] = 2'd2;
    csel[0] = (pad.left || pad.right) ? 2'd1 : 2'd0;
    csel[1] = pad.right ? 2'd2 : 2'd1;
    csel[2] = 2'd2;
    rpad    = {pad.bottom, 1'b0, pad.top};
    cpad    = {pad.right, 1'b0, pad.left};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // pad corners take the newest pixel of the block
        if (rpad[i] && cpad[j]) begin
          win[i*3 + j] = blk[2][2];
        end else begin
          win[i*3 + j] = blk[rsel[i]][csel[j]];
        end
      end
    end
  end

  assign median = median9(win);

endmodule

`default_nettype wire

>>> tb/sv/tb_median_filter_3x3_edge_pad.sv
// Self-checking bench for median_filter_3x3_edge_pad: random pixel frames through
// valid/ready with random gaps, checked against a padded-window median tracker.
// Depends on mfep_pkg and the filter RTL.

module tb_median_filter_3x3_edge_pad;
  import mfep_pkg::*;

  localparam int GAP_MAX       = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 340;
  localparam int REPORT_CAP    = 40;

  typedef enum int {PX_FULL, PX_EXTREMES, PX_NARROW} px_mix_t;

  typedef struct packed {
    pix_t             median;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } filtered_px_t;

  class median_tracker;
    pix_t         line_older [MAX_WIDTH_DEF];
    pix_t         line_recent [MAX_WIDTH_DEF];
    pix_t         col_hist [6];
    pix_t         nbhd [3][3];
    int           width_reg;
    int           height_reg;
    int           row_pos;
    int           col_pos;
    filtered_px_t pending_px [$];
    int           errors;

    function new();
      foreach (line_older[i]) begin
        line_older[i]  = '0;
        line_recent[i] = '0;
      end
      foreach (col_hist[i]) col_hist[i] = '0;
      width_reg  = IMG_W_RST;
      height_reg = IMG_H_RST;
      row_pos    = 0;
      col_pos    = 0;
      errors     = 0;
    endfunction

    function int eff_w();
      int w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
    endfunction

    function int eff_h();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    function int pending();
      return pending_px.size();
    endfunction

    // any register write restarts the frame
    function void note_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[IMG_W_W-1:0];
      else height_reg = data;
      row_pos = 0;
      col_pos = 0;
    endfunction

    // image pixel (dy,dx) of the held block, zero when outside it
    function pix_t block_px(input int dy, input int dx);
      if (dy < 0 || dy > 2 || dx < 0 || dx > 2) return '0;
      return nbhd[dy][dx];
    endfunction

    // padded coordinates; corners copy image pixel (row 1 or h-1, column 1 or w-1)
    function pix_t padded_px(input int er, input int ec, input int r, input int c,
                             input int w, input int h);
      int ir;
      int ic;
      if (er == 0 || er == h + 1) begin
        if (ec == 0) begin
          ir = (er == 0) ? 1 : h - 1;
          ic = 1;
        end else if (ec == w + 1) begin
          ir = (er == 0) ? 1 : h - 1;
          ic = w - 1;
        end else begin
          ir = (er == 0) ? 0 : h - 1;
          ic = ec - 1;
        end
      end else begin
        ir = er - 1;
        if (ec == 0) ic = 0;
        else if (ec == w + 1) ic = w - 1;
        else ic = ec - 1;
      end
      return block_px(ir - r + 2, ic - c + 2);
    endfunction

    function pix_t window_median(input int orow, input int ocol, input int r, input int c,
                                 input int w, input int h);
      pix_t v [9];
      pix_t m;
      int   n_lt;
      int   n_le;
      m = '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          v[3 * i + j] = padded_px(orow + i, ocol + j, r, c, w, h);
      // rank test: the median has at most four below it and at least five at or below
      for (int k = 0; k < 9; k++) begin
        n_lt = 0;
        n_le = 0;
        for (int j = 0; j < 9; j++) begin
          if (v[j] < v[k]) n_lt++;
          if (v[j] <= v[k]) n_le++;
        end
        if (n_lt <= 4 && n_le >= 5) m = v[k];
      end
      return m;
    endfunction

    function void queue_result(input pix_t m, input int row, input int col, input bit last);
      filtered_px_t px;
      px.median = m;
      px.row    = ROW_W'(row);
      px.col    = COL_W'(col);
      px.last   = last;
      pending_px.push_back(px);
    endfunction

    function void note_pixel(input pix_t p);
      int   w;
      int   h;
      int   r;
      int   c;
      bit   right;
      bit   bottom;
      pix_t top_old;
      pix_t mid_old;
      w = eff_w();
      h = eff_h();
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      top_old = line_older[c];
      mid_old = line_recent[c];
      for (int i = 0; i < 3; i++) begin
        nbhd[i][0] = col_hist[i];
        nbhd[i][1] = col_hist[3 + i];
      end
      nbhd[0][2] = top_old;
      nbhd[1][2] = mid_old;
      nbhd[2][2] = p;
      if (r >= 1 && c >= 1) begin
        right  = (c == w - 1);
        bottom = (r == h - 1);
        queue_result(window_median(r - 1, c - 1, r, c, w, h), r - 1, c - 1,
                     !right && !bottom);
        if (right)
          queue_result(window_median(r - 1, w - 1, r, c, w, h), r - 1, w - 1, !bottom);
        if (bottom) begin
          queue_result(window_median(h - 1, c - 1, r, c, w, h), h - 1, c - 1, !right);
          if (right)
            queue_result(window_median(h - 1, w - 1, r, c, w, h), h - 1, w - 1, 1'b1);
        end
      end
      for (int i = 0; i < 3; i++) col_hist[i] = col_hist[3 + i];
      col_hist[3] = top_old;
      col_hist[4] = mid_old;
      col_hist[5] = p;
      line_older[c]  = mid_old;
      line_recent[c] = p;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    task report(input string msg);
      if (errors < REPORT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(input pix_t median, input logic [ROW_W-1:0] row,
               input logic [COL_W-1:0] col, input logic last);
      filtered_px_t want;
      if (pending_px.size() == 0) begin
        report($sformatf("unexpected beat row %0d col %0d median %0d", row, col, median));
        return;
      end
      want = pending_px.pop_front();
      if (median !== want.median)
        report($sformatf("median at (%0d,%0d): got %0d want %0d",
                         want.row, want.col, median, want.median));
      if (row !== want.row)
        report($sformatf("row: got %0d want %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("col at row %0d: got %0d want %0d", want.row, col, want.col));
      if (last !== want.last)
        report($sformatf("last_of_run at (%0d,%0d): got %b want %b",
                         want.row, want.col, last, want.last));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pix_t                  in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pix_t                  out_median;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  out_last_of_run;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  median_tracker tracker;
  bit            no_gaps      = 1'b0;
  int            out_hold     = 0;
  int            idle_cycles  = 0;
  int            random_sent  = 0;

  median_filter_3x3_edge_pad dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_median      (out_median),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  always #4 clk = ~clk;

  // result side: check each beat, then hold ready low for a drawn stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tracker.check(out_median, out_row, out_col, out_last_of_run);
        out_hold = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_median_filter_3x3_edge_pad: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pix_t draw_pixel(input px_mix_t mix, input pix_t base);
    case (mix)
      PX_EXTREMES: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      PX_NARROW:   return base + pix_t'($urandom_range(0, 3));
      default:     return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // valid is left high after the beat so a zero gap keeps it asserted
  task automatic push_pixel(input pix_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_pixel(p);
  endtask

  task automatic send_run(input int count, input px_mix_t mix);
    pix_t base;
    int   k;
    base = pix_t'($urandom_range(0, 255));
    for (k = 0; k < count; k++) push_pixel(draw_pixel(mix, base));
  endtask

  // drain, let the pipeline settle, then write
  task automatic set_frame(input bit wr_w, input logic [CFG_DATA_W-1:0] w_val,
                           input bit wr_h, input logic [CFG_DATA_W-1:0] h_val);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (wr_w) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_IMAGE_WIDTH;
      cfg_wdata <= w_val;
      @(posedge clk);
      tracker.note_config(REG_IMAGE_WIDTH, w_val);
    end
    if (wr_h) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_IMAGE_HEIGHT;
      cfg_wdata <= h_val;
      @(posedge clk);
      tracker.note_config(REG_IMAGE_HEIGHT, h_val);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    pix_t                  directed_px [25];
    int                    w;
    int                    h;
    int                    sel;
    int                    frame_px;
    int                    count;
    logic [CFG_DATA_W-1:0] w_val;

    tracker = new();
    directed_px = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'hff, 8'h01, 8'hfe, 8'h00,
                    8'd0, 8'd200, 8'd30, 8'd90, 8'd255, 8'd60, 8'd120, 8'd15, 8'd180,
                    8'hff, 8'h00, 8'h55, 8'haa, 8'h00, 8'hff, 8'h0f, 8'hf0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: the start of row 0 gives no result
    no_gaps = 1'b1;
    send_run(16, PX_FULL);

    // widths and heights below two act as two: 2x2 frames, four results per corner
    no_gaps = 1'b0;
    set_frame(1'b1, 16'd0, 1'b1, 16'd1);
    for (int k = 0; k < 8; k++) push_pixel(directed_px[k]);
    // 3x3 with distinct values so each padded corner source shows
    set_frame(1'b1, 16'd3, 1'b1, 16'd3);
    for (int k = 8; k < 17; k++) push_pixel(directed_px[k]);
    set_frame(1'b1, 16'd1, 1'b1, 16'd4);
    for (int k = 17; k < 25; k++) push_pixel(directed_px[k]);

    while (random_sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0) w = $urandom_range(0, 1);
      else if (sel <= 6) w = $urandom_range(2, 6);
      else if (sel <= 8) w = $urandom_range(7, 12);
      else w = $urandom_range(13, 24);
      sel = $urandom_range(0, 9);
      if (sel == 0) h = $urandom_range(0, 1);
      else if (sel <= 7) h = $urandom_range(2, 5);
      else h = $urandom_range(6, 8);
      // bits above the width register are dropped by the block
      w_val = {3'($urandom_range(0, 7)), 13'(w)};
      sel = $urandom_range(0, 3);
      set_frame(sel != 1, w_val, sel != 0, 16'(h));
      frame_px = tracker.eff_w() * tracker.eff_h();
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame_px - 1);
      else count = frame_px * $urandom_range(1, 2);
      send_run(count, px_mix_t'($urandom_range(0, 2)));
      random_sent += count;
    end

    // tallest frame, cut short by the next write
    no_gaps = ($urandom_range(0, 1) == 0);
    set_frame(1'b1, 16'd2, 1'b1, 16'hffff);
    send_run(60, PX_FULL);
    // widest setting: all width bits set, a short stretch of row 0
    no_gaps = ($urandom_range(0, 1) == 0);
    set_frame(1'b1, 16'hffff, 1'b1, 16'd2);
    send_run(24, PX_FULL);

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_median_filter_3x3_edge_pad: clean");
    end else begin
      $display("tb_median_filter_3x3_edge_pad: errors");
    end
    $finish;
  end

endmodule
